/* src/ufrc_pkg.sv */
// shared types and constants for the disjoint-set core
// no dependencies; imported by every module of the block
`default_nettype none

package ufrc_pkg;

   // element count; element fields are IDX_W bits, so NUM_ELEMENTS <= 2**IDX_W
   localparam int unsigned NUM_ELEMENTS = 1024;
   localparam int unsigned IDX_W        = 10;
   localparam int unsigned RANK_W       = 4;
   localparam int unsigned CMD_W        = 2;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [RANK_W-1:0] rank_type;

   localparam logic [IDX_W:0] NUM_ELEMENTS_VEC = NUM_ELEMENTS[IDX_W:0];
   localparam idx_type        LAST_IDX         = idx_type'(NUM_ELEMENTS - 1);
   localparam rank_type       RANK_INIT        = rank_type'(1);
   localparam rank_type       RANK_MAX         = rank_type'(15);

   typedef enum logic [CMD_W-1:0] {
      CMD_FIND  = 2'd0,
      CMD_UNITE = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   // one table word: rank and parent of an element
   typedef struct packed {
      rank_type rank;
      idx_type  parent;
   } entry_type;

   typedef struct packed {
      logic      we;
      idx_type   waddr;
      entry_type wdata;
      idx_type   raddr;
   } mem_req_type;

   typedef struct packed {
      logic    valid;
      idx_type root;
      logic    merged;
   } result_type;

   function automatic logic in_range(idx_type x);
      return {1'b0, x} < NUM_ELEMENTS_VEC;
   endfunction

endpackage

`default_nettype wire

/* src/ufrc_table.sv */
// parent/rank table: one write port, one read port, registered read data
// depends on ufrc_pkg for the entry and request types
`default_nettype none

module ufrc_table (
   input  logic                   clock,
   input  ufrc_pkg::mem_req_type  mem_req,
   output ufrc_pkg::entry_type    rd_data
);
   import ufrc_pkg::*;

   entry_type mem_ff [NUM_ELEMENTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem_ff[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/ufrc_walk.sv */
// sequencer for find, unite and clear: walks parent links through the table,
// compresses paths, links roots by rank; depends on ufrc_pkg
`default_nettype none

module ufrc_walk (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_cmd,
   input  ufrc_pkg::idx_type      req_first,
   input  ufrc_pkg::idx_type      req_second,
   output ufrc_pkg::mem_req_type  mem_req,
   input  ufrc_pkg::entry_type    rd_data,
   input  logic                   slot_free,
   output ufrc_pkg::result_type   result
);
   import ufrc_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_UP    = 7'b0000100,
      S_DOWN  = 7'b0001000,
      S_LINK  = 7'b0010000,
      S_BUMP  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   idx_type   clr_cnt_ff, clr_cnt_in;
   logic      clr_rsp_ff, clr_rsp_in;
   logic      pass_b_ff, pass_b_in;
   cmd_type   cmd_ff, cmd_in;
   idx_type   b_ff, b_in;
   idx_type   node_ff, node_in;
   idx_type   start_ff, start_in;
   idx_type   top_ff, top_in;
   rank_type  rank_top_ff, rank_top_in;
   idx_type   ra_ff, ra_in;
   rank_type  rank_a_ff, rank_a_in;
   idx_type   rb_ff, rb_in;
   rank_type  rank_b_ff, rank_b_in;
   idx_type   root_ff, root_in;
   logic      merged_ff, merged_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         clr_rsp_ff <= 1'b0;
         pass_b_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         clr_rsp_ff <= clr_rsp_in;
         pass_b_ff  <= pass_b_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      b_ff        <= b_in;
      node_ff     <= node_in;
      start_ff    <= start_in;
      top_ff      <= top_in;
      rank_top_ff <= rank_top_in;
      ra_ff       <= ra_in;
      rank_a_ff   <= rank_a_in;
      rb_ff       <= rb_in;
      rank_b_ff   <= rank_b_in;
      root_ff     <= root_in;
      merged_ff   <= merged_in;
   end

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_rsp_in  = clr_rsp_ff;
      pass_b_in   = pass_b_ff;
      cmd_in      = cmd_ff;
      b_in        = b_ff;
      node_in     = node_ff;
      start_in    = start_ff;
      top_in      = top_ff;
      rank_top_in = rank_top_ff;
      ra_in       = ra_ff;
      rank_a_in   = rank_a_ff;
      rb_in       = rb_ff;
      rank_b_in   = rank_b_ff;
      root_in     = root_ff;
      merged_in   = merged_ff;
      mem_req     = '{we: 1'b0, waddr: node_ff, wdata: rd_data, raddr: node_ff};
      req_ready   = 1'b0;
      result      = '{valid: 1'b0, root: root_ff, merged: merged_ff};

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_cnt_ff;
            mem_req.wdata = '{rank: RANK_INIT, parent: clr_cnt_ff};
            clr_cnt_in    = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_IDX) begin
               clr_cnt_in = '0;
               clr_rsp_in = 1'b0;
               root_in    = '0;
               merged_in  = 1'b0;
               state_in   = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = cmd_type'(req_cmd);
               b_in      = req_second;
               node_in   = req_first;
               start_in  = req_first;
               pass_b_in = 1'b0;
               merged_in = 1'b0;
               root_in   = '0;
               unique case (req_cmd) inside
                  CMD_FIND, CMD_UNITE: begin
                     if (in_range(req_first)) begin
                        mem_req.raddr = req_first;
                        state_in      = S_UP;
                     end else begin
                        // index past the table is its own root
                        root_in  = req_first;
                        state_in = S_DONE;
                     end
                  end
                  CMD_CLEAR: begin
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_UP: begin
            // rd_data holds the word of node_ff
            if (rd_data.parent == node_ff) begin
               top_in        = node_ff;
               rank_top_in   = rd_data.rank;
               node_in       = start_ff;
               mem_req.raddr = start_ff;
               state_in      = S_DOWN;
            end else begin
               node_in       = rd_data.parent;
               mem_req.raddr = rd_data.parent;
            end
         end
         S_DOWN: begin
            if (node_ff == top_ff) begin
               if (!pass_b_ff) begin
                  ra_in     = top_ff;
                  rank_a_in = rank_top_ff;
                  if (cmd_ff == CMD_UNITE && in_range(b_ff)) begin
                     pass_b_in     = 1'b1;
                     node_in       = b_ff;
                     start_in      = b_ff;
                     mem_req.raddr = b_ff;
                     state_in      = S_UP;
                  end else begin
                     root_in  = top_ff;
                     state_in = S_DONE;
                  end
               end else begin
                  rb_in     = top_ff;
                  rank_b_in = rank_top_ff;
                  if (top_ff == ra_ff) begin
                     root_in  = ra_ff;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_LINK;
                  end
               end
            end else begin
               // point this node at the root, fetch the next one up
               mem_req.we    = 1'b1;
               mem_req.waddr = node_ff;
               mem_req.wdata = '{rank: rd_data.rank, parent: top_ff};
               mem_req.raddr = rd_data.parent;
               node_in       = rd_data.parent;
            end
         end
         S_LINK: begin
            mem_req.we = 1'b1;
            merged_in  = 1'b1;
            if (rank_a_ff < rank_b_ff) begin
               mem_req.waddr = ra_ff;
               mem_req.wdata = '{rank: rank_a_ff, parent: rb_ff};
               root_in       = rb_ff;
               state_in      = S_DONE;
            end else begin
               mem_req.waddr = rb_ff;
               mem_req.wdata = '{rank: rank_b_ff, parent: ra_ff};
               root_in       = ra_ff;
               state_in      = (rank_a_ff == rank_b_ff) ? S_BUMP : S_DONE;
            end
         end
         S_BUMP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ra_ff;
            mem_req.wdata = '{rank: (rank_a_ff == RANK_MAX) ? RANK_MAX
                                    : rank_type'(rank_a_ff + 1'b1),
                              parent: ra_ff};
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               result.valid = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // the table has no read-during-write bypass, so compression must never
   // read the entry it is rewriting
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DOWN && mem_req.we) |-> mem_req.waddr != mem_req.raddr)
      else $error("compression write collides with read");

   a_merge_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && merged_ff) |-> (root_ff == ra_ff || root_ff == rb_ff))
      else $error("merged result root is neither linked root");

   a_merge_unite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && merged_ff) |-> (cmd_ff == CMD_UNITE && pass_b_ff))
      else $error("merge reported without a unite");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !mem_req.we)
      else $error("table written outside an operation");

endmodule

`default_nettype wire

/* src/union_find_rank_compress_core.sv */
// Disjoint-set core over 1024 elements (union by rank, path compression).
// One command is worked at a time. A find walks the d links from the element to
// its root (d at most 10 with union by rank): one table read per link going up,
// one read-modify-write per link going down, all through the single read and
// single write port of the table. A unite runs two finds and, if the roots differ,
// links them, bumping the rank of the new root on equal ranks. Clear, and reset,
// sweep the table one entry a cycle; no command is taken during the sweep.
// The result sits in an output register, so the next command is taken while an
// earlier result waits for its transfer.
// depends on ufrc_pkg, ufrc_table, ufrc_walk
`default_nettype none

module union_find_rank_compress_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // first_element[9:0], second_element[19:10], zero pad
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // root[9:0], merged[10], zero pad
);
   import ufrc_pkg::*;

   mem_req_type mem_req;
   entry_type   rd_data;
   result_type  result;
   logic        slot_free;

   logic        rsp_valid_ff, rsp_valid_in;
   idx_type     rsp_root_ff, rsp_root_in;
   logic        rsp_merged_ff, rsp_merged_in;

   ufrc_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ufrc_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_first  (req_tdata[IDX_W-1:0]),
      .req_second (req_tdata[2*IDX_W-1:IDX_W]),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .slot_free  (slot_free),
      .result     (result)
   );

   // output slot frees as soon as its transfer completes
   assign slot_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in  = result.valid || (rsp_valid_ff && !rsp_tready);
   assign rsp_root_in   = result.valid ? result.root : rsp_root_ff;
   assign rsp_merged_in = result.valid ? result.merged : rsp_merged_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_root_ff   <= rsp_root_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_merged_ff, rsp_root_ff};

endmodule

`default_nettype wire

/* tb/tb_union_find_rank_compress_core.sv */
// self-checking testbench for union_find_rank_compress_core: directed and random
// find / unite / clear commands, predicted by a disjoint-set scoreboard class
// depends on ufrc_pkg and union_find_rank_compress_core
`default_nettype none

module tb_union_find_rank_compress_core;
   import ufrc_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int               IDLE_LIMIT = 20000;
   localparam int               TAIL_CYCLES = 64;
   localparam int               MAX_REPORTS = 10;

   // shadow disjoint-set table and queue of expected outcomes
   class uf_scoreboard;
      typedef struct packed {
         idx_type root;
         logic    merged;
      } outcome_type;

      idx_type     parent_of [NUM_ELEMENTS];
      rank_type    rank_of [NUM_ELEMENTS];
      outcome_type expected_q [$];
      int          failures;

      function new();
         failures = 0;
         clear_sets();
      endfunction

      function void clear_sets();
         for (int i = 0; i < NUM_ELEMENTS; i++) begin
            parent_of[i] = idx_type'(i);
            rank_of[i]   = RANK_INIT;
         end
      endfunction

      // walk up to the root, then point every node on the path at it
      function idx_type find_root(idx_type node);
         idx_type top;
         idx_type walk;
         idx_type up;
         int      steps;
         if (node >= NUM_ELEMENTS) return node;
         top   = node;
         steps = 0;
         while (parent_of[top] != top && steps < NUM_ELEMENTS) begin
            top = parent_of[top];
            steps++;
         end
         walk  = node;
         steps = 0;
         while (walk != top && steps < NUM_ELEMENTS) begin
            up              = parent_of[walk];
            parent_of[walk] = top;
            walk            = up;
            steps++;
         end
         return top;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, idx_type a, idx_type b);
         outcome_type res;
         idx_type     ra;
         idx_type     rb;
         res = '0;
         if (cmd == CMD_FIND) begin
            res.root = find_root(a);
         end else if (cmd == CMD_UNITE) begin
            ra = find_root(a);
            if (a < NUM_ELEMENTS && b < NUM_ELEMENTS) begin
               rb = find_root(b);
               if (ra != rb) begin
                  res.merged = 1'b1;
                  if (rank_of[ra] < rank_of[rb]) begin
                     parent_of[ra] = rb;
                     ra            = rb;
                  end else if (rank_of[ra] > rank_of[rb]) begin
                     parent_of[rb] = ra;
                  end else begin
                     // equal ranks: first root wins
                     parent_of[rb] = ra;
                     if (rank_of[ra] < RANK_MAX) rank_of[ra] = rank_of[ra] + 1'b1;
                  end
               end
            end
            res.root = ra;
         end else if (cmd == CMD_CLEAR) begin
            clear_sets();
         end
         expected_q.push_back(res);
      endfunction

      function void report(string what, int exp_val, int got_val);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", what, exp_val, got_val);
      endfunction

      function void check_result(idx_type got_root, logic got_merged);
         outcome_type exp_res;
         if (expected_q.size() == 0) begin
            report("unexpected result root", -1, got_root);
            return;
         end
         exp_res = expected_q.pop_front();
         if (got_root !== exp_res.root) report("root", exp_res.root, got_root);
         if (got_merged !== exp_res.merged) report("merged", exp_res.merged, got_merged);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // first_element[9:0], second_element[19:10], zero pad
   logic [1:0]  req_tuser = '0;   // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // root[9:0], merged[10], zero pad

   uf_scoreboard sb = new();
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           items_sent = 0;
   int           idle_cycles = 0;
   idx_type      window_base = '0;

   union_find_rank_compress_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check each transfer, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[9:0], rsp_tdata[10]);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic drive_item(logic [CMD_W-1:0] cmd, idx_type a, idx_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, b, a};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, a, b);
      items_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // mostly a small window so sets grow, some extremes and full range
   function automatic idx_type pick_element();
      int r;
      r = $urandom_range(99);
      if (r < 55) return idx_type'(window_base + $urandom_range(31));
      if (r < 65) return $urandom_range(1) ? LAST_IDX : idx_type'(0);
      return idx_type'($urandom_range(NUM_ELEMENTS - 1));
   endfunction

   task automatic random_item();
      int               r;
      logic [CMD_W-1:0] cmd;
      r = $urandom_range(99);
      if (r < 2)       cmd = CMD_CLEAR;
      else if (r < 5)  cmd = CMD_UNUSED;
      else if (r < 52) cmd = CMD_UNITE;
      else             cmd = CMD_FIND;
      drive_item(cmd, pick_element(), pick_element());
   endtask

   // pairwise unites over an aligned block build a tree of depth k,
   // then a find on the deepest leaf exercises a long compression walk
   task automatic grow_tree(int k);
      int size;
      int base;
      int s;
      int i;
      size = 1 << k;
      base = $urandom_range(NUM_ELEMENTS / size - 1) * size;
      if ($urandom_range(1))
         drive_item(CMD_CLEAR, idx_type'($urandom), idx_type'($urandom));
      for (s = 1; s < size; s = s * 2) begin
         for (i = base; i < base + size; i += 2 * s) begin
            if ($urandom_range(9) < 8)
               drive_item(CMD_UNITE, idx_type'(i), idx_type'(i + s));
            else
               drive_item(CMD_UNITE, idx_type'(i + s), idx_type'(i));
         end
      end
      drive_item(CMD_FIND, idx_type'(base + size - 1), idx_type'($urandom));
      repeat (4)
         drive_item(CMD_FIND, idx_type'(base + $urandom_range(size - 1)), idx_type'($urandom));
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      int target;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      window_base    = idx_type'($urandom);
      target         = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(99) < 4) grow_tree($urandom_range(2, 7));
         else random_item();
         if ($urandom_range(99) < 2) window_base = idx_type'($urandom);
      end
      wait_drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, rank ordering, same-set unites, unused command, clear
      drive_item(CMD_FIND,   10'd0,    10'd0);
      drive_item(CMD_FIND,   LAST_IDX, LAST_IDX);
      drive_item(CMD_UNITE,  10'd0,    LAST_IDX);
      drive_item(CMD_UNITE,  LAST_IDX, 10'd0);
      drive_item(CMD_UNITE,  10'd5,    10'd5);
      drive_item(CMD_UNITE,  10'd1,    10'd2);
      drive_item(CMD_UNITE,  10'd3,    10'd1);
      drive_item(CMD_UNITE,  10'd1,    10'd0);
      drive_item(CMD_FIND,   LAST_IDX, 10'd682);
      drive_item(CMD_FIND,   LAST_IDX, 10'd0);
      drive_item(CMD_UNITE,  10'd682,  10'd341);
      drive_item(CMD_UNITE,  10'd3,    10'd682);
      drive_item(CMD_FIND,   10'd341,  10'd682);
      drive_item(CMD_UNITE,  10'd1022, LAST_IDX);
      drive_item(CMD_UNUSED, LAST_IDX, LAST_IDX);
      drive_item(CMD_UNUSED, 10'd0,    10'd0);
      drive_item(CMD_FIND,   10'd2,    10'd0);
      drive_item(CMD_CLEAR,  LAST_IDX, LAST_IDX);
      drive_item(CMD_FIND,   LAST_IDX, 10'd0);
      drive_item(CMD_FIND,   10'd3,    10'd0);
      drive_item(CMD_UNITE,  LAST_IDX, 10'd0);
      drive_item(CMD_CLEAR,  10'd0,    10'd0);
      wait_drain();

      run_phase(0,  0,  240);
      run_phase(77, 0,  240);
      run_phase(0,  77, 240);
      run_phase(6,  6,  240);

      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
